// ===== hw/rtl/binary_search_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// binary search table assertion macros
// shared property shorthands for the search table core
// ----------------------------------------------------------------------------
`ifndef BINARY_SEARCH_TABLE_CORE_MACROS_SVH
`define BINARY_SEARCH_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bst assertion failed");

// next-cycle implication, checked out of reset
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bst assertion failed");

`endif

// ===== hw/rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// types, constants and helpers of the binary search table core
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                        func;
        logic [IDX_W-1:0]            entry_index;
        logic signed [KEY_WIDTH-1:0] key;
        logic [BOUND_W-1:0]          range_low;
        logic [BOUND_W-1:0]          range_high;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } t_out_word;

    typedef struct packed {
        logic wr_en;
        logic load;
        logic step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic load_empty;
        logic hit;
        logic miss_next;
    } t_sts;

    function automatic logic [BOUND_W-1:0] clamp_bound(input logic [BOUND_W-1:0] b);
        logic [BOUND_W-1:0] lim;
        lim = BOUND_W'(TABLE_DEPTH);
        return (b > lim) ? lim : b;
    endfunction

    function automatic logic [BOUND_W-1:0] mid_of(input logic [BOUND_W-1:0] lo,
                                                  input logic [BOUND_W-1:0] hi);
        logic [BOUND_W-1:0] span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

endpackage

// ===== hw/rtl/bst_datapath.sv =====
// ----------------------------------------------------------------------------
// bst_datapath
// key table memory, search bounds, probe compare and result register
// ----------------------------------------------------------------------------
module bst_datapath (
    input  logic              i_clk,
    input  bst_pkg::t_in_word i_data,
    input  bst_pkg::t_cmd     i_cmd,
    output bst_pkg::t_sts     o_sts,
    output bst_pkg::t_out_word o_data
);
    import bst_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_table [TABLE_DEPTH];
    logic signed [KEY_WIDTH-1:0] r_rdata;
    logic signed [KEY_WIDTH-1:0] r_target;
    logic [BOUND_W-1:0]          r_lo;
    logic [BOUND_W-1:0]          r_hi;
    logic [IDX_W-1:0]            r_mid;
    logic                        r_found;
    logic [IDX_W-1:0]            r_match;
    t_out_word                   r_out;

    logic [BOUND_W-1:0] w_lo_in;
    logic [BOUND_W-1:0] w_hi_in;
    logic [BOUND_W-1:0] w_mid_in;
    logic [BOUND_W-1:0] n_lo;
    logic [BOUND_W-1:0] n_hi;
    logic [BOUND_W-1:0] w_mid_step;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_less;
    logic               w_greater;

    always_comb begin
        w_lo_in  = clamp_bound(i_data.range_low);
        w_hi_in  = clamp_bound(i_data.range_high);
        w_mid_in = mid_of(w_lo_in, w_hi_in);

        w_less    = r_rdata < r_target;
        w_greater = r_rdata > r_target;
        n_lo = r_lo;
        n_hi = r_hi;
        if (w_less) begin
            n_lo = BOUND_W'(r_mid) + BOUND_W'(1);
        end else if (w_greater) begin
            n_hi = BOUND_W'(r_mid);
        end
        w_mid_step = mid_of(n_lo, n_hi);

        o_sts.load_empty = w_lo_in >= w_hi_in;
        o_sts.hit        = !w_less && !w_greater;
        o_sts.miss_next  = (w_less || w_greater) && (n_lo >= n_hi);

        // next probe address: from the new word or from the narrowed range
        w_rd_addr = i_cmd.load ? w_mid_in[IDX_W-1:0] : w_mid_step[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_table[i_data.entry_index] <= i_data.key;
        end
        r_rdata <= r_table[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo     <= w_lo_in;
            r_hi     <= w_hi_in;
            r_mid    <= w_mid_in[IDX_W-1:0];
            r_target <= i_data.key;
            r_found  <= 1'b0;
            r_match  <= '0;
        end else if (i_cmd.step) begin
            if (o_sts.hit) begin
                r_found <= 1'b1;
                r_match <= r_mid;
            end else begin
                r_lo  <= n_lo;
                r_hi  <= n_hi;
                r_mid <= w_mid_step[IDX_W-1:0];
            end
        end
        if (i_cmd.push) begin
            r_out.found       <= r_found;
            r_out.match_index <= r_match;
        end
    end

    assign o_data = r_out;

endmodule

// ===== hw/rtl/bst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bst_ctrl
// sequencer for table writes, probe iterations and result hand-off
// ----------------------------------------------------------------------------
module bst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    output logic          o_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output bst_pkg::t_cmd o_cmd,
    input  bst_pkg::t_sts i_sts
);
    import bst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_func == FUNC_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = i_sts.load_empty ? S_DONE : S_PROBE;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                o_cmd.step = 1'b1;
                if (i_sts.hit || i_sts.miss_next) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output slot to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/binary_search_table_core.sv =====
// ----------------------------------------------------------------------------
// binary_search_table_core
// sorted key table with iterative binary search
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready / i_data. func write stores key at
//   entry_index and gives no result word; func search looks for key in
//   the half-open range [range_low, range_high), bounds saturate to 64.
// output channel: o_valid / i_ready / o_data, one word per search with
//   found and match_index (match_index is 0 on a miss).
// a search runs from accept through k probe steps, k = 0..7 (0 for an
//   empty range), then waits in the done state for the output slot and
//   pushes to the result register; o_ready stays low from the accept until
//   that push. each probe is one read of the table read port plus one key
//   compare, so k follows the halving count of the range.
// reset clears the sequencer and the output valid; table contents are
//   undefined until written.
// a stalled receiver holds the result; writes and the next search are
//   still accepted, and a finished search waits until the slot frees.
// ----------------------------------------------------------------------------
module binary_search_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bst_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bst_pkg::t_out_word o_data
);
    import bst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_data.func),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    bst_datapath u_datapath (
        .i_clk  (i_clk),
        .i_data (i_data),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_data (o_data)
    );

`include "binary_search_table_core_macros.svh"

    `BST_ASSERT_IMPL(a_miss_index_zero, i_clk, i_rst_n, o_valid && !o_data.found, o_data.match_index == '0)
    `BST_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, i_valid && o_ready && (i_data.func == FUNC_SEARCH), !o_ready)
    `BST_ASSERT_IMPL(a_push_not_idle, i_clk, i_rst_n, w_cmd.push, !o_ready && !w_cmd.step)

endmodule
